FILE: rtl/mhpd_pkg.sv
`default_nettype none

package mhpd_pkg;

   // byte that is skipped quietly while hunting
   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   // register reset values
   localparam logic [7:0]  MAGIC_FIRST_RST  = 8'd170;
   localparam logic [7:0]  MAGIC_SECOND_RST = 8'd85;
   localparam logic [31:0] MAX_PAYLOAD_RST  = 32'd1024;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      CSR_MAGIC_FIRST  = 2'd0,
      CSR_MAGIC_SECOND = 2'd1,
      CSR_MAX_PAYLOAD  = 2'd2
   } csr_index_type;

   // deframer phases
   typedef enum logic [3:0] {
      PH_HUNT   = 4'd0,
      PH_SECOND = 4'd1,
      PH_TYPE   = 4'd2,
      PH_SEQ    = 4'd3,
      PH_LEN0   = 4'd4,
      PH_LEN1   = 4'd5,
      PH_LEN2   = 4'd6,
      PH_LEN3   = 4'd7,
      PH_DATA   = 4'd8
   } phase_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_PAYLOAD = 3'd0,
      KIND_EMPTY   = 3'd1,
      KIND_START   = 3'd2,
      KIND_SECOND  = 3'd3,
      KIND_LONG    = 3'd4
   } kind_type;

   typedef struct packed {
      logic [7:0]  magic_first;
      logic [7:0]  magic_second;
      logic [31:0] max_payload;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [7:0]  pkt_type;
      logic [7:0]  seq_no;
      logic [31:0] pkt_length;
      logic        last;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/mhpd_if.sv
`default_nettype none

// received byte channel
interface mhpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// deframed result channel
interface mhpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  data;
   logic [7:0]  pkt_type;
   logic [7:0]  seq_no;
   logic [31:0] pkt_length;
   logic        last;

   modport source (output valid, output kind, output data, output pkt_type,
                   output seq_no, output pkt_length, output last, input ready);
   modport sink   (input valid, input kind, input data, input pkt_type,
                   input seq_no, input pkt_length, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/mhpd_parser.sv
`default_nettype none

module mhpd_parser (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    step_en,
   input  wire  [7:0]             rx_byte,
   input  wire  mhpd_pkg::cfg_type cfg,
   output logic                   res_valid,
   output mhpd_pkg::result_type   res
);
   import mhpd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  expected_ff, expected_in;
   logic        little_ff, little_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  seq_ff, seq_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] len_shift;

   // shift the new length byte in, in the order the magic selected
   assign len_shift = little_ff ? {rx_byte, len_ff[31:8]} : {len_ff[23:0], rx_byte};

   // next state and result for the current word
   always_comb begin
      phase_in    = phase_ff;
      expected_in = expected_ff;
      little_in   = little_ff;
      type_in     = type_ff;
      seq_in      = seq_ff;
      len_in      = len_ff;
      left_in     = left_ff;
      res_valid   = 1'b0;
      res.kind       = KIND_PAYLOAD;
      res.data       = rx_byte;
      res.pkt_type   = type_ff;
      res.seq_no     = seq_ff;
      res.pkt_length = len_ff;
      res.last       = 1'b1;

      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == 8'd0) begin
               phase_in = PH_HUNT;
            end else if (rx_byte == cfg.magic_second) begin
               expected_in = cfg.magic_first;
               little_in   = 1'b1;
               phase_in    = PH_SECOND;
            end else if (rx_byte == cfg.magic_first) begin
               expected_in = cfg.magic_second;
               little_in   = 1'b0;
               phase_in    = PH_SECOND;
            end else if (rx_byte != NEWLINE_BYTE) begin
               res_valid      = 1'b1;
               res.kind       = KIND_START;
               res.pkt_type   = 8'd0;
               res.seq_no     = 8'd0;
               res.pkt_length = 32'd0;
            end
         end
         PH_SECOND: begin
            if (rx_byte == expected_ff) begin
               phase_in = PH_TYPE;
            end else begin
               phase_in       = PH_HUNT;
               res_valid      = 1'b1;
               res.kind       = KIND_SECOND;
               res.pkt_type   = 8'd0;
               res.seq_no     = 8'd0;
               res.pkt_length = 32'd0;
            end
         end
         PH_TYPE: begin
            type_in  = rx_byte;
            phase_in = PH_SEQ;
         end
         PH_SEQ: begin
            seq_in   = rx_byte;
            len_in   = 32'd0;
            phase_in = PH_LEN0;
         end
         PH_LEN0, PH_LEN1, PH_LEN2: begin
            len_in   = len_shift;
            phase_in = phase_type'(phase_ff + 4'd1);
         end
         PH_LEN3: begin
            len_in         = len_shift;
            res.pkt_length = len_shift;
            if (len_shift > cfg.max_payload) begin
               phase_in  = PH_HUNT;
               res_valid = 1'b1;
               res.kind  = KIND_LONG;
            end else if (len_shift == 32'd0) begin
               phase_in  = PH_HUNT;
               res_valid = 1'b1;
               res.kind  = KIND_EMPTY;
               res.data  = 8'd0;
            end else begin
               left_in  = len_shift;
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            left_in   = left_ff - 32'd1;
            res_valid = 1'b1;
            res.last  = (left_ff == 32'd1);
            if (left_ff == 32'd1) begin
               phase_in = PH_HUNT;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   // advance state only when the word is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         expected_ff <= 8'd0;
         little_ff   <= 1'b0;
         type_ff     <= 8'd0;
         seq_ff      <= 8'd0;
         len_ff      <= 32'd0;
         left_ff     <= 32'd0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         expected_ff <= expected_in;
         little_ff   <= little_in;
         type_ff     <= type_in;
         seq_ff      <= seq_in;
         len_ff      <= len_in;
         left_ff     <= left_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/magic_header_packet_deframer_top.sv
`default_nettype none

// Magic-header packet deframer. Takes one received byte per cycle on req_chan,
// finds a two-byte magic start in either order (that order sets the byte order
// of the four-byte length), reads the type and sequence bytes and streams each
// payload byte out on rsp_chan with the header fields, marking the last one.
// Header errors and empty packets come out as single events with last set.
// That rate holds only while the result slot is free or drains; a byte passes
// through the input register, then the result register, with the combinational
// header state update between them. Registers may be written only while no
// byte is in flight.
module magic_header_packet_deframer_top (
   input  wire               clock,
   input  wire               reset,
   mhpd_req_if.sink          req_chan,
   mhpd_rsp_if.source        rsp_chan,
   input  wire               csr_we,
   input  wire  [1:0]        csr_index,
   input  wire  [31:0]       csr_wdata
);
   import mhpd_pkg::*;

   cfg_type     cfg_ff;
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   logic        out_free;
   logic        step_en;
   logic        res_valid;
   result_type  res;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_first  <= MAGIC_FIRST_RST;
         cfg_ff.magic_second <= MAGIC_SECOND_RST;
         cfg_ff.max_payload  <= MAX_PAYLOAD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAGIC_FIRST:  cfg_ff.magic_first  <= csr_wdata[7:0];
            CSR_MAGIC_SECOND: cfg_ff.magic_second <= csr_wdata[7:0];
            CSR_MAX_PAYLOAD:  cfg_ff.max_payload  <= csr_wdata;
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   // handshake: a word moves on when the result slot is free or drains
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign step_en        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_valid_ff <= 1'b1;
      end else if (step_en) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   mhpd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .rx_byte   (in_byte_ff),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en && res_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.kind       = out_ff.kind;
   assign rsp_chan.data       = out_ff.data;
   assign rsp_chan.pkt_type   = out_ff.pkt_type;
   assign rsp_chan.seq_no     = out_ff.seq_no;
   assign rsp_chan.pkt_length = out_ff.pkt_length;
   assign rsp_chan.last       = out_ff.last;

endmodule

`default_nettype wire
